// ===== hdl/rgb_hls_color_converter_macros.svh =====
// Assertion helpers used by the converter top module.
`ifndef RGB_HLS_COLOR_CONVERTER_MACROS_SVH
`define RGB_HLS_COLOR_CONVERTER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RHC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rhc assertion failed: lbl");

// Next-cycle implication, checked out of reset.
`define RHC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rhc assertion failed: lbl");

`endif

// ===== hdl/rhc_pkg.sv =====
`default_nettype none
package rhc_pkg;

  localparam logic [14:0] HueFull  = 15'd23040;
  localparam logic [14:0] Hue60    = 15'd3840;
  localparam logic [14:0] Hue120   = 15'd7680;
  localparam logic [14:0] Hue180   = 15'd11520;
  localparam logic [14:0] Hue240   = 15'd15360;
  localparam logic [16:0] Q16One   = 17'd65536;
  localparam logic [16:0] Q16Half  = 17'd32768;
  localparam logic [8:0]  ChanMax  = 9'd255;
  localparam logic [8:0]  SumFull  = 9'd510;

  // floor(y/255) = (y * LumRecip) >> 24 for y up to 65280
  localparam logic [16:0] LumRecip = 17'd65794;
  // floor(x/15) = (x * Div15Recip) >> 16 for x below 4096
  localparam logic [12:0] Div15Recip = 13'd4370;

  localparam int DivSteps   = 17;
  localparam int HueBits    = 15;
  localparam int RhcLatency = 20;
  localparam int HlsStages  = 8;

  typedef struct packed {
    logic [14:0] hue;
    logic [16:0] lum;
    logic [16:0] sat;
  } hls_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage
`default_nettype wire

// ===== hdl/rhc_req_if.sv =====
`default_nettype none
interface rhc_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red_in;
  logic [7:0]  green_in;
  logic [7:0]  blue_in;
  logic [14:0] hue_in;
  logic [16:0] lum_in;
  logic [16:0] sat_in;

  modport source (output valid, red_in, green_in, blue_in, hue_in, lum_in, sat_in,
                  input ready);
  modport sink (input valid, red_in, green_in, blue_in, hue_in, lum_in, sat_in,
                output ready);
endinterface
`default_nettype wire

// ===== hdl/rhc_rsp_if.sv =====
`default_nettype none
interface rhc_rsp_if;
  logic        valid;
  logic        ready;
  logic [14:0] hue_out;
  logic [16:0] lum_out;
  logic [16:0] sat_out;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;

  modport source (output valid, hue_out, lum_out, sat_out, red_out, green_out, blue_out,
                  input ready);
  modport sink (input valid, hue_out, lum_out, sat_out, red_out, green_out, blue_out,
                output ready);
endinterface
`default_nettype wire

// ===== hdl/rgb_hls_color_converter.sv =====
`default_nettype none
// Per-pixel RGB/HLS converter. The direction register picks RGB to HLS (0) or
// HLS to RGB (1); write it only while no pixel is in flight. One request is
// taken per clock while the output slot is free or being taken. Results
// leave in order; the 17-stage restoring divider that forms saturation and
// hue sets most of the depth. A stalled output holds the whole pipeline, so
// no result is dropped. Fields of the direction not in use read as zero.
`include "rgb_hls_color_converter_macros.svh"
module rgb_hls_color_converter (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_data_i,
  rhc_req_if.sink    req_i,
  rhc_rsp_if.source  rsp_o
);

  localparam int Last = rhc_pkg::RhcLatency - 1;

  logic                    direction_q;
  logic [Last:0]           valid_q;
  logic [Last:0]           mode_q;
  logic                    en;
  rhc_pkg::hls_t           hls;
  rhc_pkg::rgb_t           rgb;

  // advance whenever the output slot is free or being taken
  assign en          = !valid_q[Last] || rsp_o.ready;
  assign req_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= 1'b0;
      valid_q     <= '0;
      mode_q      <= '0;
    end else begin
      if (cfg_we_i) direction_q <= cfg_data_i;
      if (en) begin
        valid_q <= {valid_q[Last-1:0], req_i.valid};
        mode_q  <= {mode_q[Last-1:0], direction_q};
      end
    end
  end

  rhc_rgb2hls u_rgb2hls (
    .clk_i   (clk_i),
    .en_i    (en),
    .red_i   (req_i.red_in),
    .green_i (req_i.green_in),
    .blue_i  (req_i.blue_in),
    .hls_o   (hls)
  );

  rhc_hls2rgb u_hls2rgb (
    .clk_i (clk_i),
    .en_i  (en),
    .hue_i (req_i.hue_in),
    .lum_i (req_i.lum_in),
    .sat_i (req_i.sat_in),
    .rgb_o (rgb)
  );

  assign rsp_o.valid     = valid_q[Last];
  assign rsp_o.hue_out   = mode_q[Last] ? '0 : hls.hue;
  assign rsp_o.lum_out   = mode_q[Last] ? '0 : hls.lum;
  assign rsp_o.sat_out   = mode_q[Last] ? '0 : hls.sat;
  assign rsp_o.red_out   = mode_q[Last] ? rgb.red : '0;
  assign rsp_o.green_out = mode_q[Last] ? rgb.green : '0;
  assign rsp_o.blue_out  = mode_q[Last] ? rgb.blue : '0;

  `RHC_ASSERT_NXT(a_stall_holds, !en, $stable(valid_q) && $stable(mode_q))
  `RHC_ASSERT_IMP(a_grey_hue, rsp_o.valid && !mode_q[Last] && rsp_o.sat_out == '0, rsp_o.hue_out == '0)
  `RHC_ASSERT_IMP(a_hls_range, rsp_o.valid, rsp_o.hue_out <= rhc_pkg::HueFull && rsp_o.lum_out <= rhc_pkg::Q16One && rsp_o.sat_out <= rhc_pkg::Q16One)

endmodule
`default_nettype wire

// ===== hdl/rhc_rgb2hls.sv =====
`default_nettype none
module rhc_rgb2hls (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [7:0]    red_i,
  input  wire logic [7:0]    green_i,
  input  wire logic [7:0]    blue_i,
  output rhc_pkg::hls_t      hls_o
);

  typedef enum logic [1:0] {MaxRed, MaxGreen, MaxBlue} max_sel_e;

  typedef struct packed {
    logic [24:0] sat_rem;
    logic [16:0] sat_q;
    logic [22:0] hue_rem;
    logic [14:0] hue_q;
    logic [8:0]  den;
    logic [7:0]  diff;
    logic [16:0] lum;
    logic        grey;
  } div_t;

  // stage A: extremes and sector
  logic [7:0]        mx, mn;
  max_sel_e          sel;
  logic signed [8:0] delta;

  always_comb begin
    mx = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    if (blue_i == mx) begin
      sel   = MaxBlue;
      delta = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end else if (green_i == mx) begin
      sel   = MaxGreen;
      delta = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      sel   = MaxRed;
      delta = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end
  end

  logic [7:0]        a_diff_q;
  logic [8:0]        a_sum_q;
  max_sel_e          a_sel_q;
  logic signed [8:0] a_delta_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_diff_q  <= mx - mn;
      a_sum_q   <= {1'b0, mx} + {1'b0, mn};
      a_sel_q   <= sel;
      a_delta_q <= delta;
    end
  end

  // stage B: products
  logic [14:0] base;
  always_comb begin
    case (a_sel_q)
      MaxBlue:  base = rhc_pkg::Hue240;
      MaxGreen: base = rhc_pkg::Hue120;
      default:  base = rhc_pkg::HueFull;
    endcase
  end

  logic [22:0]        b_bm_q;
  logic signed [21:0] b_dp_q;
  logic [22:0]        b_full_q;
  logic [7:0]         b_diff_q;
  logic [8:0]         b_den_q;
  logic [32:0]        b_lprod_q;
  logic [8:0]         b_sum_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_bm_q    <= 23'(base) * 23'(a_diff_q);
      b_dp_q    <= 22'(a_delta_q) * $signed(22'(rhc_pkg::Hue60));
      b_full_q  <= 23'(rhc_pkg::HueFull) * 23'(a_diff_q);
      b_diff_q  <= a_diff_q;
      b_den_q   <= (a_sum_q <= rhc_pkg::ChanMax) ? a_sum_q : rhc_pkg::SumFull - a_sum_q;
      b_lprod_q <= 33'({a_sum_q, 7'b0}) * 33'(rhc_pkg::LumRecip);
      b_sum_q   <= a_sum_q;
    end
  end

  // stage C: hue numerator with wrap, luminance
  logic signed [24:0] numf, full_s;
  div_t               div_d0;

  always_comb begin
    full_s = $signed({2'b0, b_full_q});
    numf   = $signed({2'b0, b_bm_q}) + 25'(b_dp_q);
    if (numf > full_s) numf = numf - full_s;
    div_d0.sat_rem = {b_diff_q, 17'b0} >> 1;
    div_d0.sat_q   = '0;
    div_d0.hue_rem = numf[22:0];
    div_d0.hue_q   = '0;
    div_d0.den     = b_den_q;
    div_d0.diff    = b_diff_q;
    div_d0.lum     = 17'({b_sum_q, 7'b0}) + 17'(b_lprod_q[32:24]);
    div_d0.grey    = (b_diff_q == 8'd0);
  end

  div_t div_q [rhc_pkg::DivSteps+1];

  always_ff @(posedge clk_i) begin
    if (en_i) div_q[0] <= div_d0;
  end

  // restoring division, one quotient bit per stage (hue bits only below bit 15)
  for (genvar k = 0; k < rhc_pkg::DivSteps; k++) begin : g_div
    localparam int Bit = rhc_pkg::DivSteps - 1 - k;
    logic [24:0] sat_trial;
    logic [22:0] hue_rem_n;
    logic [14:0] hue_q_n;
    div_t        nxt;

    if (Bit < rhc_pkg::HueBits) begin : g_hue
      logic [22:0] hue_trial;
      always_comb begin
        hue_trial = 23'(div_q[k].diff) << Bit;
        hue_rem_n = div_q[k].hue_rem;
        hue_q_n   = div_q[k].hue_q;
        if (div_q[k].hue_rem >= hue_trial) begin
          hue_rem_n    = div_q[k].hue_rem - hue_trial;
          hue_q_n[Bit] = 1'b1;
        end
      end
    end else begin : g_nohue
      assign hue_rem_n = div_q[k].hue_rem;
      assign hue_q_n   = div_q[k].hue_q;
    end

    always_comb begin
      sat_trial   = 25'(div_q[k].den) << Bit;
      nxt         = div_q[k];
      nxt.hue_rem = hue_rem_n;
      nxt.hue_q   = hue_q_n;
      if (div_q[k].sat_rem >= sat_trial) begin
        nxt.sat_rem    = div_q[k].sat_rem - sat_trial;
        nxt.sat_q[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) div_q[k+1] <= nxt;
    end
  end

  assign hls_o.hue = div_q[rhc_pkg::DivSteps].grey ? '0 : div_q[rhc_pkg::DivSteps].hue_q;
  assign hls_o.sat = div_q[rhc_pkg::DivSteps].grey ? '0 : div_q[rhc_pkg::DivSteps].sat_q;
  assign hls_o.lum = div_q[rhc_pkg::DivSteps].lum;

endmodule
`default_nettype wire

// ===== hdl/rhc_hls2rgb.sv =====
`default_nettype none
module rhc_hls2rgb (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [14:0]   hue_i,
  input  wire logic [16:0]   lum_i,
  input  wire logic [16:0]   sat_i,
  output rhc_pkg::rgb_t      rgb_o
);

  localparam int PadLen = rhc_pkg::RhcLatency - rhc_pkg::HlsStages;

  // ramp position 0..3840: rising edge, top plateau, falling edge or zero
  function automatic logic [11:0] ramp_pos(input logic [14:0] rh);
    logic [14:0] t;
    begin
      if (rh < rhc_pkg::Hue60) t = rh;
      else if (rh < rhc_pkg::Hue180) t = rhc_pkg::Hue60;
      else if (rh < rhc_pkg::Hue240) t = rhc_pkg::Hue240 - rh;
      else t = '0;
      return t[11:0];
    end
  endfunction

  // stage 1: hue wrap, lum/sat clamp and per-channel hue
  logic [14:0] h;
  logic [16:0] l, s;
  logic [15:0] rh_red;
  logic [14:0] rh_red_w, rh_blue;

  always_comb begin
    h = (hue_i > rhc_pkg::HueFull) ? hue_i - rhc_pkg::HueFull : hue_i;
    l = (lum_i > rhc_pkg::Q16One) ? rhc_pkg::Q16One : lum_i;
    s = (sat_i > rhc_pkg::Q16One) ? rhc_pkg::Q16One : sat_i;
    rh_red = 16'(h) + 16'(rhc_pkg::Hue120);
    rh_red_w = (rh_red > 16'(rhc_pkg::HueFull)) ? 15'(rh_red - 16'(rhc_pkg::HueFull))
                                                : rh_red[14:0];
    rh_blue = (h >= rhc_pkg::Hue120) ? h - rhc_pkg::Hue120
                                     : h + (rhc_pkg::HueFull - rhc_pkg::Hue120);
  end

  logic [16:0] s1_l_q, s1_s_q, s2_l_q, s3_l_q;
  logic [11:0] s1_t_q [3], s2_t_q [3], s3_t_q [3], s4_t_q [3];
  logic [32:0] s2_ls_q, s3_e_q, s4_lo_q, s4_d_q, s5_lo_q;
  logic [44:0] s5_m_q [3], s6_v_q [3];
  logic [11:0] s7_x_q [3];
  logic [7:0]  s8_c_q [3];
  logic [16:0] s2_s_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_l_q    <= l;
      s1_s_q    <= s;
      s1_t_q[0] <= ramp_pos(rh_red_w);
      s1_t_q[1] <= ramp_pos(h);
      s1_t_q[2] <= ramp_pos(rh_blue);
      // stage 2: l*s
      s2_ls_q <= 33'(s1_l_q) * 33'(s1_s_q);
      s2_l_q  <= s1_l_q;
      s2_s_q  <= s1_s_q;
      s2_t_q  <= s1_t_q;
      // stage 3: half spread between the intermediates
      s3_e_q <= (s2_l_q <= rhc_pkg::Q16Half) ? s2_ls_q : {s2_s_q, 16'b0} - s2_ls_q;
      s3_l_q <= s2_l_q;
      s3_t_q <= s2_t_q;
      // stage 4: low intermediate and full spread
      s4_lo_q <= {s3_l_q, 16'b0} - s3_e_q;
      s4_d_q  <= {s3_e_q[31:0], 1'b0};
      s4_t_q  <= s3_t_q;
      s5_lo_q <= s4_lo_q;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [52:0] w;
    logic [24:0] qp;
    assign w  = {s6_v_q[c], 8'b0} - 53'(s6_v_q[c]);
    assign qp = 25'(s7_x_q[c]) * 25'(rhc_pkg::Div15Recip);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s5_m_q[c] <= 45'(s4_d_q) * 45'(s4_t_q[c]);
        s6_v_q[c] <= 45'(s5_lo_q) * 45'(rhc_pkg::Hue60) + s5_m_q[c];
        s7_x_q[c] <= w[51:40];
        s8_c_q[c] <= qp[23:16];
      end
    end
  end

  rhc_pkg::rgb_t pad_q [PadLen];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pad_q[0] <= '{red: s8_c_q[0], green: s8_c_q[1], blue: s8_c_q[2]};
      for (int i = 1; i < PadLen; i++) pad_q[i] <= pad_q[i-1];
    end
  end

  assign rgb_o = pad_q[PadLen-1];

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import rhc_pkg::*;

  typedef enum logic {DirRgbToHls = 1'b0, DirHlsToRgb = 1'b1} direction_e;
  typedef enum int {BusySender, BusyReceiver, NoIdle} idle_mode_e;

  typedef struct packed {
    hls_t hls;
    rgb_t rgb;
  } pixel_result_t;

  typedef struct {
    direction_e    dir;
    logic [7:0]    red, green, blue;
    logic [14:0]   hue;
    logic [16:0]   lum, sat;
    bit            typed;
    pixel_result_t known;
  } stim_row_t;

  logic clk_i, rst_ni, cfg_we_i, cfg_data_i;
  rhc_req_if req_bus ();
  rhc_rsp_if rsp_bus ();

  rgb_hls_color_converter DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus)
  );

  direction_e    cur_dir;
  idle_mode_e    idle_mode;
  int            send_idle_pct, recv_idle_pct;
  pixel_result_t pending_results[$];
  int            mismatches, results_seen, requests_sent;
  int            rgb_requests, hls_requests;

  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  always @(negedge clk_i) begin
    rsp_bus.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [7:0] ramp_level(longint unsigned lo, longint unsigned hi,
                                            int rh);
    longint unsigned v;
    if (rh > int'(HueFull)) rh -= int'(HueFull);
    else if (rh < 0) rh += int'(HueFull);
    if (rh < int'(Hue60)) v = lo * Hue60 + (hi - lo) * longint'(rh);
    else if (rh < int'(Hue180)) v = hi * Hue60;
    else if (rh < int'(Hue240)) v = lo * Hue60 + (hi - lo) * longint'(int'(Hue240) - rh);
    else v = lo * Hue60;
    return 8'((v * 255) / (longint'(Hue60) << 32));
  endfunction

  function automatic pixel_result_t rgb_to_hls(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pixel_result_t res;
    int mx, mn, sum, diff, den;
    longint num;
    res = '0;
    mx = int'(r); mn = int'(r);
    if (int'(g) > mx) mx = int'(g);
    if (int'(b) > mx) mx = int'(b);
    if (int'(g) < mn) mn = int'(g);
    if (int'(b) < mn) mn = int'(b);
    sum = mx + mn;
    diff = mx - mn;
    res.hls.lum = 17'((longint'(sum) * 65536) / 510);
    if (diff != 0) begin
      den = (sum <= 255) ? sum : 510 - sum;
      res.hls.sat = 17'((longint'(diff) * 65536) / den);
      if (int'(b) == mx)
        num = longint'(Hue240) * diff + longint'(Hue60) * (int'(r) - int'(g));
      else if (int'(g) == mx)
        num = longint'(Hue120) * diff + longint'(Hue60) * (int'(b) - int'(r));
      else num = longint'(HueFull) * diff + longint'(Hue60) * (int'(g) - int'(b));
      // keep exactly 360 degrees, wrap anything beyond
      if (num > longint'(HueFull) * diff) num -= longint'(HueFull) * diff;
      res.hls.hue = 15'(num / diff);
    end
    return res;
  endfunction

  function automatic pixel_result_t hls_to_rgb(logic [14:0] h_in, logic [16:0] l_in,
                                              logic [16:0] s_in);
    pixel_result_t res;
    int h;
    longint unsigned l, s, hi, lo;
    res = '0;
    h = int'(h_in); l = 64'(l_in); s = 64'(s_in);
    if (h > int'(HueFull)) h -= int'(HueFull);
    if (l > 65536) l = 65536;
    if (s > 65536) s = 65536;
    if (s == 0) begin
      res.rgb.red = 8'((l * 255) >> 16);
      res.rgb.green = res.rgb.red;
      res.rgb.blue = res.rgb.red;
    end else begin
      if (l <= 32768) hi = l * 65536 + l * s;
      else hi = l * 65536 + s * 65536 - l * s;
      lo = 2 * l * 65536 - hi;
      res.rgb.red = ramp_level(lo, hi, h + int'(Hue120));
      res.rgb.green = ramp_level(lo, hi, h);
      res.rgb.blue = ramp_level(lo, hi, h - int'(Hue120));
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    pixel_result_t got, want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      got.hls = '{rsp_bus.hue_out, rsp_bus.lum_out, rsp_bus.sat_out};
      got.rgb = '{rsp_bus.red_out, rsp_bus.green_out, rsp_bus.blue_out};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d mismatch: expected %p, got %p", results_seen, want, got);
        end
      end
    end
  end

  task automatic set_direction(direction_e d);
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (RhcLatency + 5) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_data_i = d;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cur_dir = d;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_pixel(stim_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid = 1'b1;
    req_bus.red_in = row.red;
    req_bus.green_in = row.green;
    req_bus.blue_in = row.blue;
    req_bus.hue_in = row.hue;
    req_bus.lum_in = row.lum;
    req_bus.sat_in = row.sat;
    do @(posedge clk_i); while (!req_bus.ready);
    if (row.typed) pending_results.push_back(row.known);
    else if (cur_dir == DirRgbToHls)
      pending_results.push_back(rgb_to_hls(row.red, row.green, row.blue));
    else pending_results.push_back(hls_to_rgb(row.hue, row.lum, row.sat));
    requests_sent++;
    if (cur_dir == DirRgbToHls) rgb_requests++;
    else hls_requests++;
    @(negedge clk_i);
  endtask

  function automatic stim_row_t random_row(direction_e d);
    stim_row_t row;
    logic [7:0] top;
    row = '{dir: d, default: '0};
    row.red = 8'($urandom); row.green = 8'($urandom); row.blue = 8'($urandom);
    row.hue = 15'($urandom); row.lum = 17'($urandom); row.sat = 17'($urandom);
    top = 8'($urandom);
    case ($urandom_range(9))
      0: begin
        row.green = row.red; row.blue = row.red;
      end
      1: begin
        row.green = top; row.blue = top; row.red = 8'($urandom_range(32'(top)));
      end
      2: begin
        row.red = top; row.green = top; row.blue = 8'($urandom_range(32'(top)));
      end
      3: row.sat = '0;
      default: begin
        // mostly keep HLS inputs in their nominal range
        row.hue = 15'($urandom_range(32'(HueFull)));
        row.lum = 17'($urandom_range(32'(Q16One)));
        row.sat = 17'($urandom_range(32'(Q16One)));
      end
    endcase
    return row;
  endfunction

  stim_row_t directed[$];

  initial begin
    cfg_we_i = 1'b0; cfg_data_i = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.red_in = '0; req_bus.green_in = '0; req_bus.blue_in = '0;
    req_bus.hue_in = '0; req_bus.lum_in = '0; req_bus.sat_in = '0;
    rsp_bus.ready = 1'b0;
    send_idle_pct = 0; recv_idle_pct = 0;
    mismatches = 0; results_seen = 0; requests_sent = 0;
    rgb_requests = 0; hls_requests = 0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed = '{
      '{DirRgbToHls, 0, 0, 0, 0, 0, 0, 1, '{'{0, 0, 0}, '{0, 0, 0}}},
      '{DirRgbToHls, 255, 255, 255, 0, 0, 0, 1, '{'{0, 65536, 0}, '{0, 0, 0}}},
      '{DirRgbToHls, 255, 0, 0, 0, 0, 0, 1, '{'{23040, 32768, 65536}, '{0, 0, 0}}},
      '{DirRgbToHls, 0, 255, 0, 0, 0, 0, 0, '0},
      '{DirRgbToHls, 0, 0, 255, 0, 0, 0, 0, '0},
      '{DirRgbToHls, 128, 128, 128, 0, 0, 0, 0, '0},
      '{DirRgbToHls, 0, 200, 200, 0, 0, 0, 0, '0},
      '{DirRgbToHls, 200, 200, 10, 0, 0, 0, 0, '0},
      '{DirRgbToHls, 255, 100, 0, 0, 0, 0, 0, '0},
      '{DirRgbToHls, 255, 0, 100, 0, 0, 0, 0, '0},
      '{DirRgbToHls, 250, 240, 10, 0, 0, 0, 0, '0},
      '{DirRgbToHls, 200, 100, 55, 0, 0, 0, 0, '0},
      '{DirHlsToRgb, 0, 0, 0, 0, 0, 0, 1, '{'{0, 0, 0}, '{0, 0, 0}}},
      '{DirHlsToRgb, 0, 0, 0, 0, 65536, 0, 1, '{'{0, 0, 0}, '{255, 255, 255}}},
      '{DirHlsToRgb, 0, 0, 0, 32767, 131071, 0, 1, '{'{0, 0, 0}, '{255, 255, 255}}},
      '{DirHlsToRgb, 0, 0, 0, 0, 32768, 65536, 0, '0},
      '{DirHlsToRgb, 0, 0, 0, 23040, 32768, 65536, 0, '0},
      '{DirHlsToRgb, 0, 0, 0, 32767, 40000, 131071, 0, '0},
      '{DirHlsToRgb, 0, 0, 0, 7680, 20000, 131071, 0, '0},
      '{DirHlsToRgb, 0, 0, 0, 15360, 50000, 30000, 0, '0},
      '{DirHlsToRgb, 0, 0, 0, 3840, 32769, 1, 0, '0},
      '{DirHlsToRgb, 0, 0, 0, 20000, 131071, 65536, 0, '0}
    };

    set_direction(DirRgbToHls);
    foreach (directed[i]) begin
      if (directed[i].dir != cur_dir) begin
        req_bus.valid = 1'b0;
        set_direction(directed[i].dir);
      end
      send_pixel(directed[i]);
    end

    for (int m = 0; m < 3; m++) begin
      idle_mode = idle_mode_e'(m);
      case (idle_mode)
        BusySender: begin
          send_idle_pct = 34; recv_idle_pct = 77;
        end
        BusyReceiver: begin
          send_idle_pct = 77; recv_idle_pct = 34;
        end
        default: begin
          send_idle_pct = 0; recv_idle_pct = 0;
        end
      endcase
      for (int d = 0; d < 2; d++) begin
        req_bus.valid = 1'b0;
        set_direction(cur_dir == DirRgbToHls ? DirHlsToRgb : DirRgbToHls);
        repeat (64) send_pixel(random_row(cur_dir));
      end
    end
    req_bus.valid = 1'b0;

    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (RhcLatency + 10) @(negedge clk_i);
    $display("%0d pixels converted (%0d RGB to HLS, %0d HLS to RGB), %0d results checked",
             requests_sent, rgb_requests, hls_requests, results_seen);
    $display("idle patterns: sender-heavy, receiver-heavy and none; %0d mismatches",
             mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
